@@ sv/cda_pkg.sv @@
package cda_pkg;

  // field widths
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int WDAY_W   = 3;
  localparam int AMT_W    = 16;
  localparam int KIND_W   = 2;

  // internal widths
  localparam int DW       = 17;  // signed running day count
  localparam int CENT_W   = 8;   // year / 100
  localparam int REM100_W = 7;   // year % 100
  localparam int YLEN_W   = 9;   // 365 or 366
  localparam int MT_W     = 17;  // biased month total
  localparam int Q12_W    = 13;
  localparam int ZS_W     = 11;  // zeller sum before mod 7
  localparam int ZQ_W     = 9;

  localparam int MAX_YEAR_DEF    = 9999;
  localparam int START_YEAR_RST  = 2000;
  localparam int START_MONTH_RST = 1;
  localparam int START_DAY_RST   = 1;

  // reciprocal constants for division by 100, 12 and 7
  localparam int RC100_W  = 13;
  localparam int RECIP100 = 5243;
  localparam int SHIFT100 = 19;
  localparam int RC12_W   = 18;
  localparam int RECIP12  = 174763;
  localparam int SHIFT12  = 21;
  localparam int RC7_W    = 14;
  localparam int RECIP7   = 9363;
  localparam int SHIFT7   = 16;

  // bias in whole years that keeps the month total non-negative
  localparam int MON_BIAS = 2731;

  typedef enum logic [KIND_W-1:0] {
    KIND_DAYS   = 2'd0,
    KIND_MONTHS = 2'd1,
    KIND_YEARS  = 2'd2,
    KIND_RELOAD = 2'd3
  } cda_kind_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_WALK,
    OP_MON_MUL,
    OP_MON_FIX,
    OP_YR_CHK,
    OP_SPLIT_MUL,
    OP_SPLIT_FIX,
    OP_CLAMP,
    OP_ZSUM,
    OP_ZMUL,
    OP_EMIT
  } cda_op_e;

  typedef struct packed {
    logic walk_done;
    logic walk_fail;
    logic year_bad;
  } cda_sts_t;

  // leap year from year / 100 and year % 100 (year % 4 equals rem % 4)
  function automatic logic cda_leap(input logic [CENT_W-1:0] cent,
                                    input logic [REM100_W-1:0] rem);
    cda_leap = (rem[1:0] == 2'b00) && ((rem != '0) || (cent[1:0] == 2'b00));
  endfunction

  function automatic logic [DAY_W-1:0] cda_month_len(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
    unique case (m)
      4'd2:                      cda_month_len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   cda_month_len = 5'd30;
      default:                   cda_month_len = 5'd31;
    endcase
  endfunction

  // floor(13 * (m + 1) / 5) with january and february as months 13 and 14
  function automatic logic [5:0] cda_zeller_mterm(input logic [MONTH_W-1:0] m);
    unique case (m)
      4'd1:    cda_zeller_mterm = 6'd36;
      4'd2:    cda_zeller_mterm = 6'd39;
      4'd3:    cda_zeller_mterm = 6'd10;
      4'd4:    cda_zeller_mterm = 6'd13;
      4'd5:    cda_zeller_mterm = 6'd15;
      4'd6:    cda_zeller_mterm = 6'd18;
      4'd7:    cda_zeller_mterm = 6'd20;
      4'd8:    cda_zeller_mterm = 6'd23;
      4'd9:    cda_zeller_mterm = 6'd26;
      4'd10:   cda_zeller_mterm = 6'd28;
      4'd11:   cda_zeller_mterm = 6'd31;
      4'd12:   cda_zeller_mterm = 6'd33;
      default: cda_zeller_mterm = 6'd0;
    endcase
  endfunction

endpackage

@@ sv/cda_ctrl.sv @@
module cda_ctrl import cda_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  cda_kind_e kind_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  cda_sts_t  sts_i,
  output cda_op_e   op_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK,
    S_MON_MUL,
    S_MON_FIX,
    S_YR_CHK,
    S_SPLIT_MUL,
    S_SPLIT_FIX,
    S_CLAMP,
    S_ZSUM,
    S_ZMUL,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // sequencing of one word through the datapath
  always_comb begin
    state_d     = state_q;
    op_o        = OP_NONE;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o = OP_LOAD;
          unique case (kind_i)
            KIND_DAYS:   state_d = S_WALK;
            KIND_MONTHS: state_d = S_MON_MUL;
            KIND_YEARS:  state_d = S_YR_CHK;
            KIND_RELOAD: state_d = S_SPLIT_MUL;
          endcase
        end
      end
      S_WALK: begin
        op_o = OP_WALK;
        if (sts_i.walk_done || sts_i.walk_fail) begin
          state_d = S_ZSUM;
        end
      end
      S_MON_MUL: begin
        op_o    = OP_MON_MUL;
        state_d = S_MON_FIX;
      end
      S_MON_FIX: begin
        op_o    = OP_MON_FIX;
        state_d = S_YR_CHK;
      end
      S_YR_CHK: begin
        op_o    = OP_YR_CHK;
        state_d = sts_i.year_bad ? S_ZSUM : S_SPLIT_MUL;
      end
      S_SPLIT_MUL: begin
        op_o    = OP_SPLIT_MUL;
        state_d = S_SPLIT_FIX;
      end
      S_SPLIT_FIX: begin
        op_o    = OP_SPLIT_FIX;
        state_d = S_CLAMP;
      end
      S_CLAMP: begin
        op_o    = OP_CLAMP;
        state_d = S_ZSUM;
      end
      S_ZSUM: begin
        op_o    = OP_ZSUM;
        state_d = S_ZMUL;
      end
      S_ZMUL: begin
        op_o    = OP_ZMUL;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          op_o        = OP_EMIT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ sv/cda_dp.sv @@
module cda_dp import cda_pkg::*; #(
  parameter int MAX_YEAR = MAX_YEAR_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cda_op_e                  op_i,
  input  cda_kind_e                kind_i,
  input  logic signed [AMT_W-1:0]  amount_i,
  input  logic [YEAR_W-1:0]        start_year_i,
  input  logic [MONTH_W-1:0]       start_month_i,
  input  logic [DAY_W-1:0]         start_day_i,
  output cda_sts_t                 sts_o,
  output logic [YEAR_W-1:0]        out_year_o,
  output logic [MONTH_W-1:0]       out_month_o,
  output logic [DAY_W-1:0]         out_day_o,
  output logic [WDAY_W-1:0]        weekday_o,
  output logic                     range_error_o
);

  localparam int RST_YEAR = (START_YEAR_RST < MAX_YEAR) ? START_YEAR_RST : MAX_YEAR;
  localparam logic [YEAR_W-1:0]   MAX_Y     = YEAR_W'(MAX_YEAR);
  localparam logic [YEAR_W-1:0]   MIN_Y     = YEAR_W'(1);
  localparam logic signed [DW-1:0] MAX_Y_S  = DW'(MAX_YEAR);
  localparam logic signed [DW-1:0] ONE_S    = DW'(1);
  localparam logic signed [DW-1:0] DEC_LEN_S = DW'(31);
  localparam logic signed [DW-1:0] BIAS_S   = DW'(MON_BIAS);
  localparam logic [MT_W-1:0]     MT_BIAS   = MT_W'(MON_BIAS * 12);
  localparam logic [MONTH_W-1:0]  JAN       = MONTH_W'(1);
  localparam logic [MONTH_W-1:0]  FEB       = MONTH_W'(2);
  localparam logic [MONTH_W-1:0]  DEC       = MONTH_W'(12);
  localparam logic [REM100_W-1:0] REM_TOP   = REM100_W'(99);

  // committed date with its century split
  logic [YEAR_W-1:0]   cur_year_q;
  logic [MONTH_W-1:0]  cur_month_q;
  logic [DAY_W-1:0]    cur_day_q;
  logic [CENT_W-1:0]   cur_cent_q;
  logic [REM100_W-1:0] cur_rem_q;

  // working copy
  logic [YEAR_W-1:0]    wy_q;
  logic [MONTH_W-1:0]   wm_q;
  logic signed [DW-1:0] wd_q;
  logic [CENT_W-1:0]    wc_q;
  logic [REM100_W-1:0]  wr_q;
  logic signed [DW-1:0] ny_q;
  logic [MT_W-1:0]      mt_q;
  logic [Q12_W-1:0]     q12_q;
  logic [CENT_W-1:0]    p100_q;
  logic                 err_q;
  logic [ZS_W-1:0]      zsum_q;
  logic [ZQ_W-1:0]      zq_q;

  logic [YEAR_W-1:0]   out_year_q;
  logic [MONTH_W-1:0]  out_month_q;
  logic [DAY_W-1:0]    out_day_q;
  logic [WDAY_W-1:0]   weekday_q;
  logic                range_error_q;

  // year step helpers on the working split
  logic [CENT_W-1:0]   wc_inc, wc_dec, cc_prev;
  logic [REM100_W-1:0] wr_inc, wr_dec, cr_prev;
  logic                lp_cur, lp_next, lp_prev;
  logic [DAY_W-1:0]    ml_cur, ml_prev;
  logic [YLEN_W-1:0]   ylen_fwd, ylen_bwd;
  logic signed [DW-1:0] ml_s, ml_prev_s, yf_s, yb_s, yb_sum;
  logic                go_fwd, go_bwd, jump_fwd, jump_bwd, at_max, at_min;
  logic                walk_done, walk_fail, year_bad;

  // load, month and split helpers
  logic [YEAR_W-1:0]    sy;
  logic [MONTH_W-1:0]   sm;
  logic signed [DW-1:0] cur_day_s, amt_s, ny_load, ny_mon;
  logic [MT_W-1:0]      mt_load, mt_rem;
  logic [MT_W+RC12_W-1:0]    prod12;
  logic [YEAR_W+RC100_W-1:0] prod100;
  logic [YEAR_W-1:0]    rem100_full;
  logic [DAY_W-1:0]     len_w, wd_clamped;
  logic signed [DW-1:0] len_s;

  // zeller helpers
  logic [CENT_W-1:0]        zj;
  logic [REM100_W-1:0]      zk;
  logic [ZS_W-1:0]          zsum_d, wday_full;
  logic [ZS_W+RC7_W-1:0]    prod7;

  // neighbouring years of the working split, and the year before the committed date
  always_comb begin
    if (wr_q == REM_TOP) begin
      wc_inc = wc_q + CENT_W'(1);
      wr_inc = '0;
    end else begin
      wc_inc = wc_q;
      wr_inc = wr_q + REM100_W'(1);
    end
    if (wr_q == '0) begin
      wc_dec = wc_q - CENT_W'(1);
      wr_dec = REM_TOP;
    end else begin
      wc_dec = wc_q;
      wr_dec = wr_q - REM100_W'(1);
    end
    if (cur_rem_q == '0) begin
      cc_prev = cur_cent_q - CENT_W'(1);
      cr_prev = REM_TOP;
    end else begin
      cc_prev = cur_cent_q;
      cr_prev = cur_rem_q - REM100_W'(1);
    end
  end

  // one step of the day walk: a whole year when it fits, else a month; also the year range check
  always_comb begin
    lp_cur    = cda_leap(wc_q, wr_q);
    lp_next   = cda_leap(wc_inc, wr_inc);
    lp_prev   = cda_leap(wc_dec, wr_dec);
    ml_cur    = cda_month_len(wm_q, lp_cur);
    ml_prev   = cda_month_len(wm_q - MONTH_W'(1), lp_cur);
    ylen_fwd  = YLEN_W'(365) + YLEN_W'((wm_q <= FEB) ? lp_cur : lp_next);
    ylen_bwd  = YLEN_W'(365) + YLEN_W'((wm_q > FEB) ? lp_cur : lp_prev);
    ml_s      = $signed({{(DW-DAY_W){1'b0}}, ml_cur});
    ml_prev_s = $signed({{(DW-DAY_W){1'b0}}, ml_prev});
    yf_s      = $signed({{(DW-YLEN_W){1'b0}}, ylen_fwd});
    yb_s      = $signed({{(DW-YLEN_W){1'b0}}, ylen_bwd});
    yb_sum    = wd_q + yb_s;
    go_fwd    = wd_q > ml_s;
    go_bwd    = wd_q < ONE_S;
    jump_fwd  = wd_q > yf_s;
    jump_bwd  = yb_sum < ONE_S;
    at_max    = (wy_q == MAX_Y);
    at_min    = (wy_q == MIN_Y);
    walk_done = !go_fwd && !go_bwd;
    walk_fail = (go_fwd && at_max && (jump_fwd || (wm_q == DEC))) ||
                (go_bwd && at_min && (jump_bwd || (wm_q == JAN)));
    year_bad  = (ny_q < ONE_S) || (ny_q > MAX_Y_S);
  end

  assign sts_o = '{walk_done: walk_done, walk_fail: walk_fail, year_bad: year_bad};

  // start date clamp and item load values
  always_comb begin
    if (start_year_i == '0) begin
      sy = MIN_Y;
    end else if (start_year_i > MAX_Y) begin
      sy = MAX_Y;
    end else begin
      sy = start_year_i;
    end
    if (start_month_i == '0) begin
      sm = JAN;
    end else if (start_month_i > DEC) begin
      sm = DEC;
    end else begin
      sm = start_month_i;
    end
    cur_day_s = $signed({{(DW-DAY_W){1'b0}}, cur_day_q});
    amt_s     = $signed({{(DW-AMT_W){amount_i[AMT_W-1]}}, amount_i});
    ny_load   = $signed({{(DW-YEAR_W){1'b0}}, cur_year_q}) + amt_s;
    mt_load   = MT_W'(cur_month_q) - MT_W'(1) + MT_BIAS + MT_W'(amt_s);
  end

  // month total split by 12, year split by 100, day clamp
  always_comb begin
    prod12      = MT_W'(mt_q) * RC12_W'(RECIP12);
    mt_rem      = mt_q - MT_W'({q12_q, 3'b000}) - MT_W'({q12_q, 2'b00});
    ny_mon      = $signed({{(DW-YEAR_W){1'b0}}, cur_year_q}) +
                  $signed({{(DW-Q12_W){1'b0}}, q12_q}) - BIAS_S;
    prod100     = YEAR_W'(wy_q) * RC100_W'(RECIP100);
    rem100_full = wy_q - YEAR_W'({p100_q, 6'b0}) - YEAR_W'({p100_q, 5'b0}) -
                  YEAR_W'({p100_q, 2'b0});
    len_w       = cda_month_len(wm_q, lp_cur);
    len_s       = $signed({{(DW-DAY_W){1'b0}}, len_w});
    if (wd_q < ONE_S) begin
      wd_clamped = DAY_W'(1);
    end else if (wd_q > len_s) begin
      wd_clamped = len_w;
    end else begin
      wd_clamped = wd_q[DAY_W-1:0];
    end
  end

  // zeller congruence, january and february count in the year before
  always_comb begin
    zj = (cur_month_q <= FEB) ? cc_prev : cur_cent_q;
    zk = (cur_month_q <= FEB) ? cr_prev : cur_rem_q;
    zsum_d = ZS_W'(cur_day_q) + ZS_W'(cda_zeller_mterm(cur_month_q)) + ZS_W'(zk) +
             ZS_W'(zk[REM100_W-1:2]) + ZS_W'(zj[CENT_W-1:2]) +
             ZS_W'({zj, 2'b00}) + ZS_W'(zj);
    prod7     = ZS_W'(zsum_q) * RC7_W'(RECIP7);
    wday_full = zsum_q - ZS_W'({zq_q, 3'b000}) + ZS_W'(zq_q);
  end

  // committed date
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_year_q  <= YEAR_W'(RST_YEAR);
      cur_month_q <= MONTH_W'(START_MONTH_RST);
      cur_day_q   <= DAY_W'(START_DAY_RST);
      cur_cent_q  <= CENT_W'(RST_YEAR / 100);
      cur_rem_q   <= REM100_W'(RST_YEAR % 100);
    end else if ((op_i == OP_WALK && walk_done) || op_i == OP_CLAMP) begin
      cur_year_q  <= wy_q;
      cur_month_q <= wm_q;
      cur_day_q   <= (op_i == OP_CLAMP) ? wd_clamped : wd_q[DAY_W-1:0];
      cur_cent_q  <= wc_q;
      cur_rem_q   <= wr_q;
    end
  end

  // working registers and result word
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_LOAD: begin
        wy_q  <= cur_year_q;
        wm_q  <= cur_month_q;
        wc_q  <= cur_cent_q;
        wr_q  <= cur_rem_q;
        err_q <= 1'b0;
        ny_q  <= ny_load;
        mt_q  <= mt_load;
        unique case (kind_i)
          KIND_DAYS:               wd_q <= cur_day_s + amt_s;
          KIND_MONTHS, KIND_YEARS: wd_q <= cur_day_s;
          KIND_RELOAD: begin
            wy_q <= sy;
            wm_q <= sm;
            wd_q <= $signed({{(DW-DAY_W){1'b0}}, start_day_i});
          end
        endcase
      end
      OP_WALK: begin
        if (walk_fail) begin
          err_q <= 1'b1;
        end else if (!walk_done) begin
          if (go_fwd) begin
            if (jump_fwd) begin
              wy_q <= wy_q + YEAR_W'(1);
              wc_q <= wc_inc;
              wr_q <= wr_inc;
              wd_q <= wd_q - yf_s;
            end else begin
              wd_q <= wd_q - ml_s;
              if (wm_q == DEC) begin
                wm_q <= JAN;
                wy_q <= wy_q + YEAR_W'(1);
                wc_q <= wc_inc;
                wr_q <= wr_inc;
              end else begin
                wm_q <= wm_q + MONTH_W'(1);
              end
            end
          end else begin
            if (jump_bwd) begin
              wy_q <= wy_q - YEAR_W'(1);
              wc_q <= wc_dec;
              wr_q <= wr_dec;
              wd_q <= yb_sum;
            end else if (wm_q == JAN) begin
              wm_q <= DEC;
              wy_q <= wy_q - YEAR_W'(1);
              wc_q <= wc_dec;
              wr_q <= wr_dec;
              wd_q <= wd_q + DEC_LEN_S;
            end else begin
              wm_q <= wm_q - MONTH_W'(1);
              wd_q <= wd_q + ml_prev_s;
            end
          end
        end
      end
      OP_MON_MUL: q12_q <= prod12[SHIFT12 +: Q12_W];
      OP_MON_FIX: begin
        ny_q <= ny_mon;
        wm_q <= mt_rem[MONTH_W-1:0] + MONTH_W'(1);
      end
      OP_YR_CHK: begin
        if (year_bad) begin
          err_q <= 1'b1;
        end else begin
          wy_q <= ny_q[YEAR_W-1:0];
        end
      end
      OP_SPLIT_MUL: p100_q <= prod100[SHIFT100 +: CENT_W];
      OP_SPLIT_FIX: begin
        wc_q <= p100_q;
        wr_q <= rem100_full[REM100_W-1:0];
      end
      OP_ZSUM: zsum_q <= zsum_d;
      OP_ZMUL: zq_q <= prod7[SHIFT7 +: ZQ_W];
      OP_EMIT: begin
        out_year_q    <= cur_year_q;
        out_month_q   <= cur_month_q;
        out_day_q     <= cur_day_q;
        weekday_q     <= wday_full[WDAY_W-1:0];
        range_error_q <= err_q;
      end
      default: ;
    endcase
  end

  assign out_year_o    = out_year_q;
  assign out_month_o   = out_month_q;
  assign out_day_o     = out_day_q;
  assign weekday_o     = weekday_q;
  assign range_error_o = range_error_q;

endmodule

@@ sv/calendar_date_adder.sv @@
// Gregorian date adder with weekday.
// Input channel (in_valid_i / in_stall_o): one word is kind_i and amount_i.
// kind 0 adds amount days, 1 adds months, 2 adds years, 3 reloads the start
// date from the registers. Output channel (out_valid_o / out_stall_i): one
// word per input word with the date after the operation, its weekday
// (0 saturday .. 6 friday) and range_error_o when the result would leave
// years 1 to MAX_YEAR, in which case the date is kept.
// Each word runs through the control states: reload splits the year, clamps
// the day and computes the weekday; add years checks the year first; add
// months first splits the month total by 12; add days walks the date. The day
// walk moves one year or one month per cycle.
// One word is in work at a time; the next is taken the cycle after the
// result lands in the output register, even while that result is stalled.
// A stalled result holds its register; a finished word waits for it.
// Reset loads the start registers' reset date (2000-01-01, year held to
// MAX_YEAR). Register writes over the APB port change only the start
// registers; the date follows them on the next reload word.
module calendar_date_adder import cda_pkg::*; #(
  parameter int MAX_YEAR = MAX_YEAR_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [KIND_W-1:0]        kind_i,
  input  logic signed [AMT_W-1:0]  amount_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [YEAR_W-1:0]        out_year_o,
  output logic [MONTH_W-1:0]       out_month_o,
  output logic [DAY_W-1:0]         out_day_o,
  output logic [WDAY_W-1:0]        weekday_o,
  output logic                     range_error_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [3:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam logic [1:0] REG_START_YEAR  = 2'd0;
  localparam logic [1:0] REG_START_MONTH = 2'd1;
  localparam logic [1:0] REG_START_DAY   = 2'd2;

  logic [YEAR_W-1:0]  start_year_q;
  logic [MONTH_W-1:0] start_month_q;
  logic [DAY_W-1:0]   start_day_q;
  logic               cfg_wr;
  cda_op_e            op;
  cda_sts_t           sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // start date registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_year_q  <= YEAR_W'(START_YEAR_RST);
      start_month_q <= MONTH_W'(START_MONTH_RST);
      start_day_q   <= DAY_W'(START_DAY_RST);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_START_YEAR:  start_year_q  <= pwdata[YEAR_W-1:0];
        REG_START_MONTH: start_month_q <= pwdata[MONTH_W-1:0];
        REG_START_DAY:   start_day_q   <= pwdata[DAY_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[3:2])
      REG_START_YEAR:  prdata = 32'(start_year_q);
      REG_START_MONTH: prdata = 32'(start_month_q);
      REG_START_DAY:   prdata = 32'(start_day_q);
      default:         prdata = '0;
    endcase
  end

  cda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .kind_i      (cda_kind_e'(kind_i)),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .op_o        (op)
  );

  cda_dp #(
    .MAX_YEAR (MAX_YEAR)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .kind_i        (cda_kind_e'(kind_i)),
    .amount_i      (amount_i),
    .start_year_i  (start_year_q),
    .start_month_i (start_month_q),
    .start_day_i   (start_day_q),
    .sts_o         (sts),
    .out_year_o    (out_year_o),
    .out_month_o   (out_month_o),
    .out_day_o     (out_day_o),
    .weekday_o     (weekday_o),
    .range_error_o (range_error_o)
  );

endmodule

@@ sv/cda_checker.sv @@
module cda_checker import cda_pkg::*; #(
  parameter int MAX_YEAR = MAX_YEAR_DEF
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [YEAR_W-1:0]   out_year_o,
  input logic [MONTH_W-1:0]  out_month_o,
  input logic [DAY_W-1:0]    out_day_o,
  input logic [WDAY_W-1:0]   weekday_o,
  input logic                range_error_o
);

  localparam logic [YEAR_W-1:0] MAX_Y = YEAR_W'(MAX_YEAR);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(out_year_o) && $stable(out_month_o) &&
      $stable(out_day_o) && $stable(weekday_o) && $stable(range_error_o))
    else $error("stalled result word changed");

  // one word in work at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a word is in work");

  // result date fields in range
  a_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_month_o >= MONTH_W'(1) && out_month_o <= MONTH_W'(12) &&
                    out_day_o >= DAY_W'(1) && weekday_o <= WDAY_W'(6))
    else $error("result date field out of range");

  // result year in range
  a_year: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_year_o >= YEAR_W'(1) && out_year_o <= MAX_Y)
    else $error("result year out of range");

  // february day never beyond 29
  a_short_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_month_o == MONTH_W'(2)) |-> out_day_o <= DAY_W'(29))
    else $error("february day beyond 29");

endmodule

bind calendar_date_adder cda_checker #(
  .MAX_YEAR (MAX_YEAR)
) u_cda_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .out_year_o    (out_year_o),
  .out_month_o   (out_month_o),
  .out_day_o     (out_day_o),
  .weekday_o     (weekday_o),
  .range_error_o (range_error_o)
);
